/* hw/rtl/byte_stuffed_frame_encoder_top_assert.svh */
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder assertion macros
// Shorthand for clocked assertions; the including scope provides clk_i and
// rst_ni.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_ENCODER_TOP_ASSERT_SVH
`define BYTE_STUFFED_FRAME_ENCODER_TOP_ASSERT_SVH

// Checked at every rising edge while out of reset.
`define BSFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BSFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/bsfe_pkg.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder package
// Shared constants, the line-byte sequence type and the CRC-16/X.25 step.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MAX_BEATS = 8;
  localparam int unsigned IDX_W     = $clog2(MAX_BEATS);
  localparam int unsigned CNT_W     = $clog2(MAX_BEATS + 1);

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  // Line bytes produced by one input item, first byte in the lowest slot.
  typedef struct packed {
    logic [MAX_BEATS-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 count;
  } seq_t;

  // One byte folded into the reflected CRC, one bit per step.
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/bsfe_builder.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder sequence builder
// Holds the running CRC and frame state; a payload byte becomes an opening
// flag if new, escaped data, and at frame end escaped CRC and closing flag.
// ----------------------------------------------------------------------------
module bsfe_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_last_i,
  input  logic               consume_i,
  output bsfe_pkg::seq_t     seq_o
);
  import bsfe_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic        open_q, open_d;
  logic [15:0] crc_new;
  logic [15:0] fcs;
  seq_t        seq;

  // Append one byte at the next free slot.
  function automatic seq_t push_byte(seq_t s, logic [7:0] b);
    seq_t r;
    r = s;
    r.bytes[s.count[IDX_W-1:0]] = b;
    r.count = s.count + CNT_W'(1);
    return r;
  endfunction

  // Append one byte, escaped when it collides with a flag or escape byte.
  function automatic seq_t push_escaped(seq_t s, logic [7:0] b);
    seq_t r;
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      r = push_byte(s, ESC_BYTE);
      r = push_byte(r, b ^ ESC_XOR);
    end else begin
      r = push_byte(s, b);
    end
    return r;
  endfunction

  // The CRC restarts from its initial value when a new frame opens.
  assign crc_new = crc_update(open_q ? crc_q : CRC_INIT, data_byte_i);
  assign fcs     = crc_new ^ CRC_XOROUT;

  // Build the line-byte sequence for the current item.
  always_comb begin
    seq = '0;
    if (!open_q) begin
      seq = push_byte(seq, FLAG_BYTE);
    end
    seq = push_escaped(seq, data_byte_i);
    if (frame_last_i) begin
      seq = push_escaped(seq, fcs[7:0]);
      seq = push_escaped(seq, fcs[15:8]);
      seq = push_byte(seq, FLAG_BYTE);
    end
  end

  assign seq_o = seq;

  // Frame state advances only when the item is handed on.
  always_comb begin
    crc_d  = crc_q;
    open_d = open_q;
    if (consume_i) begin
      crc_d  = frame_last_i ? CRC_INIT : crc_new;
      open_d = !frame_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      open_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      open_q <= open_d;
    end
  end

endmodule

/* hw/rtl/bsfe_serialiser.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder output serialiser
// Holds one item's line bytes, sends one beat per cycle while not stalled
// and takes the next sequence in the cycle that the last byte leaves.
// ----------------------------------------------------------------------------
module bsfe_serialiser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bsfe_pkg::seq_t seq_i,
  input  logic           load_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import bsfe_pkg::*;

  logic [MAX_BEATS-1:0][BYTE_W-1:0] bytes_q, bytes_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic                             take;

  assign out_valid_o = (cnt_q != '0);
  assign out_last_o  = (cnt_q == CNT_W'(1));
  assign out_byte_o  = bytes_q[0];
  assign take        = out_valid_o && !out_stall_i;

  // Free for a new sequence when empty or when the final byte leaves now.
  assign ready_o = (cnt_q == '0) || (out_last_o && take);

  // Load a new sequence or shift the sent byte out.
  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      bytes_d = seq_i.bytes;
      cnt_d   = seq_i.count;
    end else if (take) begin
      bytes_d = bytes_q >> BYTE_W;
      cnt_d   = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

/* hw/rtl/byte_stuffed_frame_encoder_top.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder
// HDLC-style asynchronous framing with byte stuffing and a CRC-16/X.25 FCS.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one payload byte per beat (data_byte_i) with
//   frame_last_i set on the final byte of a frame. The output channel
//   carries one line byte per beat; out_last_o marks the final line byte
//   caused by each input beat.
//   A frame opens with a 0x7E flag; 0x7E and 0x7D are sent as 0x7D followed
//   by the byte XOR 0x20; after the last byte come the escaped FCS low and
//   high bytes and a closing 0x7E flag.
//   The first line byte of an item is offered after the item has passed
//   the input register and then the sequence register, and an item waits
//   in the input register while the serialiser is still busy.
//   An item producing n line bytes (1 to 8) occupies the output port for
//   n beats; the single output port sets the rate, so plain data bytes
//   flow at one per cycle unless the receiver stalls, escaped bytes as two.
//   Reset clears the CRC to 0xFFFF, marks no frame open and empties both
//   registers. When the receiver stalls, the current byte is held and the
//   input stalls once the input register is also full.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import bsfe_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       ser_ready;
  logic       consume;
  seq_t       seq;

  // The registered item moves on when the serialiser can take it.
  assign consume    = in_vld_q && ser_ready;
  assign in_stall_o = in_vld_q && !ser_ready;

  // Input register.
  always_comb begin
    in_vld_d = in_vld_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= data_byte_i;
      last_q <= frame_last_i;
    end
  end

  // CRC, escaping and framing of the registered item.
  bsfe_builder u_builder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_q),
    .frame_last_i (last_q),
    .consume_i    (consume),
    .seq_o        (seq)
  );

  // One line byte per output beat.
  bsfe_serialiser u_serialiser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seq_i       (seq),
    .load_i      (consume),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

/* hw/rtl/bsfe_checker.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_encoder_top_assert.svh"

module bsfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       frame_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // A stalled input beat stays offered with the same payload.
  `BSFE_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable({data_byte_i, frame_last_i}), "input beat changed under stall")

  // A stalled output beat stays offered.
  `BSFE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output beat dropped under stall")

  // A stalled output beat keeps its payload.
  `BSFE_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(out_last_o), "output payload changed under stall")

  // The line bytes of one item leave without gaps.
  `BSFE_ASSERT(a_no_gap, out_valid_o && !out_stall_i && !out_last_o |=> out_valid_o, "gap inside the line bytes of one item")

  // With nothing on the output the input is never stalled.
  `BSFE_ASSERT_ALWAYS(a_idle_ready, !out_valid_o |-> !in_stall_o, "input stalled while output idle")

endmodule

bind byte_stuffed_frame_encoder_top bsfe_checker u_bsfe_checker (.*);

/* test/byte_stuffed_frame_encoder_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder testbench
// Feeds payload bytes in frames of varied length and content, predicts the
// line bytes (flags, stuffed data, stuffed CRC-16/X.25 FCS) and checks every
// output beat against the prediction. Both sides idle at random, and one
// long receiver hold-off forces the encoder to stall its input.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_encoder_top_test;

  // Line coding and CRC constants.
  localparam logic [7:0]  LINE_FLAG = 8'h7E;
  localparam logic [7:0]  LINE_ESC  = 8'h7D;
  localparam logic [7:0]  STUFF_XOR = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_SEED  = 16'hFFFF;
  localparam logic [15:0] FCS_INV   = 16'hFFFF;

  localparam int unsigned GAP_MAX    = 15;
  localparam int unsigned LONG_HOLD  = 240;
  localparam int unsigned SETTLE_CYC = 8;

  // Tracks the frame state and holds the line bytes still owed by the block.
  class stuffed_line_tracker;
    typedef struct packed {
      logic [7:0] value;
      logic       last;
    } line_beat_t;

    line_beat_t  beats_due[$];
    logic [15:0] fcs_reg;
    bit          in_frame;
    int unsigned mismatches;
    int unsigned beats_seen;
    int unsigned payload_seen;
    int unsigned frames_closed;
    int unsigned stuffed_bytes;

    function new();
      fcs_reg       = FCS_SEED;
      in_frame      = 1'b0;
      mismatches    = 0;
      beats_seen    = 0;
      payload_seen  = 0;
      frames_closed = 0;
      stuffed_bytes = 0;
    endfunction

    // Reflected CRC, one input bit at a time, least significant bit first.
    static function logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ b[i]) begin
          r = (r >> 1) ^ FCS_POLY;
        end else begin
          r = r >> 1;
        end
      end
      return r;
    endfunction

    function void push_beat(logic [7:0] v);
      beats_due.push_back('{value: v, last: 1'b0});
    endfunction

    function void push_stuffed(logic [7:0] v);
      if (v == LINE_FLAG || v == LINE_ESC) begin
        push_beat(LINE_ESC);
        push_beat(v ^ STUFF_XOR);
        stuffed_bytes++;
      end else begin
        push_beat(v);
      end
    endfunction

    // Works out the line bytes caused by one accepted payload beat.
    function void take_payload(logic [7:0] b, logic last_in);
      logic [15:0] fcs;
      payload_seen++;
      if (!in_frame) begin
        fcs_reg  = FCS_SEED;
        in_frame = 1'b1;
        push_beat(LINE_FLAG);
      end
      fcs_reg = crc_fold(fcs_reg, b);
      push_stuffed(b);
      if (last_in) begin
        fcs = fcs_reg ^ FCS_INV;
        push_stuffed(fcs[7:0]);
        push_stuffed(fcs[15:8]);
        push_beat(LINE_FLAG);
        fcs_reg  = FCS_SEED;
        in_frame = 1'b0;
        frames_closed++;
      end
      beats_due[beats_due.size() - 1].last = 1'b1;
    endfunction

    // Compares one accepted output beat with the oldest line byte owed.
    function void check_line_byte(logic [7:0] v, logic l);
      line_beat_t due;
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected line byte: expected none, actual %02h last %0b",
                 $time, v, l);
        mismatches++;
        return;
      end
      due = beats_due.pop_front();
      beats_seen++;
      if (v !== due.value) begin
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, due.value, v);
        mismatches++;
      end
      if (l !== due.last) begin
        $display("%0t: out_last mismatch: expected %0b, actual %0b",
                 $time, due.last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte  = 8'h00;
  logic       frame_last = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int unsigned in_gap_max  = GAP_MAX;
  int unsigned out_gap_max = GAP_MAX;
  bit          long_hold_req = 1'b0;

  stuffed_line_tracker tracker = new();

  byte_stuffed_frame_encoder_top uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .frame_last_i (frame_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .out_last_o   (out_last)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Output monitor: every accepted beat is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_line_byte(out_byte, out_last);
    end
  end

  // Receiver: a random hold-off before each beat, or one long one on request.
  initial begin
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = $urandom_range(0, out_gap_max);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one payload beat after a random gap and waits until it is taken.
  task automatic send_payload(logic [7:0] b, logic l);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    frame_last <= l;
    do @(posedge clk); while (in_stall);
    tracker.take_payload(b, l);
  endtask

  // Byte values near the stuffing boundary turn up often.
  function automatic logic [7:0] pick_payload_byte();
    logic [7:0] near [4] = '{8'h5E, 8'h5D, 8'h00, 8'hFF};
    case ($urandom_range(0, 7))
      0:       return LINE_FLAG;
      1:       return LINE_ESC;
      2:       return near[$urandom_range(0, 3)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Whole frames with random content; short frames dominate.
  task automatic send_random_frames(int unsigned n_items);
    int unsigned sent;
    int unsigned left;
    sent = 0;
    while (sent < n_items) begin
      left = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      while (left > 0) begin
        send_payload(pick_payload_byte(), left == 1);
        left--;
        sent++;
      end
    end
  endtask

  // Two-byte frame whose FCS has a flag or escape in the chosen half.
  task automatic send_fcs_stuffing_frame(bit high_half);
    logic [15:0] pair;
    logic [15:0] fcs;
    logic [7:0]  sel;
    pair = 16'h0000;
    forever begin
      fcs = stuffed_line_tracker::crc_fold(
              stuffed_line_tracker::crc_fold(FCS_SEED, pair[7:0]), pair[15:8]) ^ FCS_INV;
      sel = high_half ? fcs[15:8] : fcs[7:0];
      if (sel == LINE_FLAG || sel == LINE_ESC || pair == 16'hFFFF) break;
      pair++;
    end
    send_payload(pair[7:0], 1'b0);
    send_payload(pair[15:8], 1'b1);
  endtask

  task automatic wait_drained();
    while (tracker.beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Watchdog.
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte frames at the extremes and on the stuffed values.
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(LINE_FLAG, 1'b1);
    send_payload(LINE_ESC, 1'b1);
    // A longer frame mixing stuffed and neighbouring plain bytes.
    send_payload(LINE_FLAG, 1'b0);
    send_payload(LINE_ESC, 1'b0);
    send_payload(8'h5E, 1'b0);
    send_payload(8'h5D, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b0);
    send_payload(8'hA5, 1'b1);
    // FCS bytes that need stuffing, low half and high half.
    send_fcs_stuffing_frame(1'b0);
    send_fcs_stuffing_frame(1'b1);
    send_payload(8'h55, 1'b0);
    send_payload(8'hAA, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    // Back-to-back on both sides.
    in_gap_max  = 0;
    out_gap_max = 0;
    send_random_frames(30);
    in_valid <= 1'b0;
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps offering.
    long_hold_req = 1'b1;
    send_random_frames(20);
    in_valid <= 1'b0;
    wait_drained();

    // Random gaps on both sides.
    in_gap_max  = GAP_MAX;
    out_gap_max = GAP_MAX;
    send_random_frames(40);
    in_valid <= 1'b0;
    wait_drained();

    $display("Checked %0d line bytes from %0d payload bytes in %0d frames, %0d bytes stuffed.",
             tracker.beats_seen, tracker.payload_seen, tracker.frames_closed,
             tracker.stuffed_bytes);
    $display("Traffic ran with random gaps, back to back, and under one long output hold-off.");
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bsfe_pkg.sv
hw/rtl/bsfe_builder.sv
hw/rtl/bsfe_serialiser.sv
hw/rtl/byte_stuffed_frame_encoder_top.sv
hw/rtl/bsfe_checker.sv
test/byte_stuffed_frame_encoder_top_test.sv
